[src/pct3_pkg.sv]
// Package for the three-channel periodic compare timer.
// Holds action codes, prescaler limits, default sizes and the channel control struct.
// No dependencies.
package pct3_pkg;

	// Default sizes handed to the top level parameters.
	localparam int DefNumChannels = 3;
	localparam int DefCountWidth  = 16;
	localparam int PrescaleWidth  = 7;

	// Request action codes.
	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_START = 2'd1,
		ACT_STOP  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// Prescaler select codes.
	typedef enum logic [1:0] {
		DIV_1   = 2'd0,
		DIV_8   = 2'd1,
		DIV_32  = 2'd2,
		DIV_128 = 2'd3
	} prescale_t;

	localparam prescale_t PrescaleReset = DIV_128;

	// Per-channel strobes for one processed request.
	typedef struct packed {
		logic start;
		logic stop;
		logic roll;
	} chan_ctrl_t;

	// Terminal prescaler count for each divider: the divider minus one.
	function automatic logic [PrescaleWidth-1:0] prescale_limit(input prescale_t sel);
		logic [PrescaleWidth-1:0] lim;
		case (sel)
			DIV_1:   lim = 7'd0;
			DIV_8:   lim = 7'd7;
			DIV_32:  lim = 7'd31;
			DIV_128: lim = 7'd127;
			default: lim = 7'd127;
		endcase
		return lim;
	endfunction

endpackage

[src/pct3_timebase.sv]
// Prescaler and free-running main counter of the compare timer.
// Depends on pct3_pkg.
module pct3_timebase #(
	parameter int COUNT_WIDTH = pct3_pkg::DefCountWidth
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pct3_pkg::prescale_t    prescale_sel,
	input  logic                   tick,
	output logic                   roll,
	output logic [COUNT_WIDTH-1:0] count_q,
	output logic [COUNT_WIDTH-1:0] count_new
);
	import pct3_pkg::*;

	logic [PrescaleWidth-1:0] pre_q;

	// The prescaler rolls over at or above its terminal count, so a smaller
	// divider chosen mid-count takes effect on the next tick.
	assign roll      = tick && (pre_q >= prescale_limit(prescale_sel));
	assign count_new = COUNT_WIDTH'(count_q + 1'b1);

	// Prescaler and counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q   <= '0;
			count_q <= '0;
		end else if (roll) begin
			pre_q   <= '0;
			count_q <= count_new;
		end else if (tick) begin
			pre_q   <= PrescaleWidth'(pre_q + 1'b1);
		end
	end

endmodule

[src/pct3_channel.sv]
// One periodic compare channel: period, enable and compare value.
// Depends on pct3_pkg.
module pct3_channel #(
	parameter int COUNT_WIDTH = pct3_pkg::DefCountWidth
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pct3_pkg::chan_ctrl_t   ctrl,
	input  logic [COUNT_WIDTH-1:0] period,
	input  logic [COUNT_WIDTH-1:0] count_q,
	input  logic [COUNT_WIDTH-1:0] count_new,
	output logic                   fire,
	output logic                   enable_q
);
	import pct3_pkg::*;

	logic [COUNT_WIDTH-1:0] period_q;
	logic [COUNT_WIDTH-1:0] compare_q;

	// A match is checked against the count after the increment.
	assign fire = ctrl.roll && enable_q && (compare_q == count_new);

	// Start arms at the current count plus the period; a firing re-arms
	// at the new count plus the period. A zero period waits a full wrap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= '0;
			compare_q <= '0;
			enable_q  <= 1'b0;
		end else if (ctrl.start) begin
			period_q  <= period;
			compare_q <= COUNT_WIDTH'(count_q + period);
			enable_q  <= 1'b1;
		end else if (ctrl.stop) begin
			enable_q  <= 1'b0;
		end else if (fire) begin
			compare_q <= COUNT_WIDTH'(count_new + period_q);
		end
	end

endmodule

[src/periodic_compare_timer_3ch_core.sv]
// Top level of the periodic compare timer: input register, timebase,
// compare channels and result register.
// Depends on pct3_pkg, pct3_timebase and pct3_channel.
//
// Usage: each request on the input channel (in_valid/in_ready) is a tick of
// the input clock, a start of a channel with a period, a stop of a channel,
// or no action. Every request yields exactly one result on the output channel
// (out_valid/out_ready): the mask of channels that fired, whether any
// channel is running, and the counter value after the request.
// The prescaler select is to be written through cfg_we/cfg_wdata only while
// idle; the block itself does not enforce this. From acceptance, a request
// waits in the input register, then the timebase and channel compares update
// the state and load the result register. Throughput is one request per cycle
// while the receiver does not stall. Reset clears the counter, prescaler and
// all channels (all stopped) and selects divide by 128. When the receiver
// stalls, the result register holds, the input register keeps one more
// request, and in_ready then drops until the result is taken.
module periodic_compare_timer_3ch_core #(
	parameter int NUM_CHANNELS = pct3_pkg::DefNumChannels,
	parameter int COUNT_WIDTH  = pct3_pkg::DefCountWidth
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              action,
	input  logic [1:0]              channel,
	input  logic [COUNT_WIDTH-1:0]  period,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [NUM_CHANNELS-1:0] fired_mask,
	output logic                    running,
	output logic [COUNT_WIDTH-1:0]  count_now
);
	import pct3_pkg::*;

	prescale_t              prescale_sel_q;
	logic                   valid_s1;
	action_t                action_s1;
	logic [2:0]             channel_s1;
	logic [COUNT_WIDTH-1:0] period_s1;
	logic                   advance;
	logic                   tick;
	logic                   roll;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] count_new;
	logic [NUM_CHANNELS-1:0] fire;
	logic [NUM_CHANNELS-1:0] enable;
	logic                   valid_s2;
	logic [NUM_CHANNELS-1:0] fired_s2;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_sel_q <= PrescaleReset;
		end else if (cfg_we) begin
			prescale_sel_q <= prescale_t'(cfg_wdata);
		end
	end

	// The request in the input register is processed when the result
	// register is free or being emptied.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign tick     = advance && (action_s1 == ACT_TICK);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1  <= action_t'(action);
			channel_s1 <= {1'b0, channel};
			period_s1  <= period;
		end
	end

	pct3_timebase #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_timebase (
		.clk          (clk),
		.arst_n       (arst_n),
		.prescale_sel (prescale_sel_q),
		.tick         (tick),
		.roll         (roll),
		.count_q      (count_q),
		.count_new    (count_new)
	);

	// Compare channels, each decoding its own start and stop.
	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
		chan_ctrl_t ctrl;

		always_comb begin
			ctrl.start = advance && (action_s1 == ACT_START) && (channel_s1 == 3'(i));
			ctrl.stop  = advance && (action_s1 == ACT_STOP) && (channel_s1 == 3'(i));
			ctrl.roll  = roll;
		end

		pct3_channel #(
			.COUNT_WIDTH (COUNT_WIDTH)
		) u_channel (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.period    (period_s1),
			.count_q   (count_q),
			.count_new (count_new),
			.fire      (fire[i]),
			.enable_q  (enable[i])
		);
	end

	// Result register. Counter and enables change only when a new result is
	// loaded, so they are shown straight from the state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fired_s2 <= fire;
		end
	end

	assign out_valid  = valid_s2;
	assign fired_mask = fired_s2;
	assign running    = |enable;
	assign count_now  = count_q;

	// A fired channel stays enabled, so a fired result always shows running.
	a_fire_running: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (|fired_mask)) |-> running)
		else $error("fired result without a running channel");

	// A stalled result must keep its counter and running flag.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(count_now) && $stable(running)))
		else $error("result state changed during stall");

	// A request held in the input register is not lost while blocked.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input register dropped a request");

	// With both registers full and the output stalled, no request is taken.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid && !out_ready) |-> !in_ready)
		else $error("request accepted while pipeline is full");

endmodule
